/* rtl/core/ptrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptrp_pkg;

	localparam int ROWS = 480;
	localparam int COLS = 640;

	localparam logic [3:0] ADDR_FOCAL = 4'h0;
	localparam logic [3:0] ADDR_RMIN  = 4'h4;
	localparam logic [3:0] ADDR_RMAX  = 4'h8;

	localparam logic [11:0] FOCAL_RST = 12'd520;
	localparam logic [15:0] RMIN_RST  = 16'd500;
	localparam logic [15:0] RMAX_RST  = 16'd1500;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic               point_valid;
	} point_t;

	typedef struct packed {
		logic [8:0] pixel_row;
		logic [9:0] pixel_col;
		logic [7:0] gray;
	} pixel_t;

	typedef struct packed {
		logic               v;
		logic               keep;
		logic signed [28:0] fx;
		logic signed [28:0] fy;
		logic signed [28:0] zr;
		logic signed [28:0] zc;
		logic               zneg;
		logic [15:0]        zabs;
		logic [31:0]        xx;
		logic [31:0]        yy;
		logic [31:0]        zz;
		logic [31:0]        s;
		logic [29:0]        rn;
		logic               rneg;
		logic               rovf;
		logic [9:0]         rq;
		logic [29:0]        cn;
		logic               cneg;
		logic               covf;
		logic [9:0]         cq;
		logic [16:0]        dd;
		logic               win;
		logic [47:0]        sv;
		logic [47:0]        sr;
		logic [31:0]        gn;
		logic [7:0]         gq;
	} stage_t;

endpackage

`default_nettype wire

/* rtl/core/point_to_range_pixel_projector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Projects a stream of 3-D points onto pixel writes of a range image.
// The input channel (in_valid, in_ready, in_data) takes one point per item;
// the output channel (out_valid, out_ready, out_data) gives at most one pixel
// write per point. Invalid points, points at zero depth and points that fall
// outside the image give no item.
// The pipeline takes one item every cycle unless the output stalls it; its
// depth is set by the range square root, one result bit per stage, followed
// by the gray quotient, one bit per stage.
// The APB port holds the focal length and the range window; write it only
// while no point is in flight.
// Reset empties the pipeline and restores the registers. When the receiver
// holds out_ready low with a result waiting, the whole pipeline stalls and
// in_ready falls; nothing is lost or repeated.
module point_to_range_pixel_projector (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ptrp_pkg::point_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ptrp_pkg::pixel_t     out_data,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import ptrp_pkg::*;

	localparam int NS = 36;

	logic [11:0] focal_q;
	logic [15:0] rmin_q;
	logic [15:0] rmax_q;
	logic [31:0] mnsq_q;
	logic [31:0] mxsq_q;
	logic        en;
	stage_t      pipe_s [NS];
	stage_t      nxt [NS];
	stage_t      last;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
			rmin_q  <= RMIN_RST;
			rmax_q  <= RMAX_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_FOCAL: focal_q <= pwdata[11:0];
				ADDR_RMIN:  rmin_q  <= pwdata[15:0];
				ADDR_RMAX:  rmax_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_FOCAL: prdata = {20'd0, focal_q};
			ADDR_RMIN:  prdata = {16'd0, rmin_q};
			ADDR_RMAX:  prdata = {16'd0, rmax_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		mnsq_q <= 32'(rmin_q) * 32'(rmin_q);
		mxsq_q <= 32'(rmax_q) * 32'(rmax_q);
	end

	assign last      = pipe_s[NS-1];
	assign out_valid = last.v && last.keep;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	assign out_data.pixel_row = last.rq[8:0];
	assign out_data.pixel_col = last.cq[9:0];
	assign out_data.gray      = last.win ? last.gq : 8'd0;

	always_comb begin
		logic [28:0] ra;
		logic [28:0] ca;
		logic [47:0] bitv;
		logic [47:0] t;
		logic [23:0] gt;
		logic [31:0] gd;
		ra   = '0;
		ca   = '0;
		bitv = '0;
		t    = '0;
		gt   = '0;
		gd   = {8'd0, rmax_q - rmin_q, 8'd0};

		nxt[0]      = '0;
		nxt[0].v    = in_valid;
		nxt[0].keep = in_data.point_valid && (in_data.point_z != 16'sd0);
		nxt[0].fx   = 29'(in_data.point_x) * 29'($signed({1'b0, focal_q}));
		nxt[0].fy   = 29'(in_data.point_y) * 29'($signed({1'b0, focal_q}));
		nxt[0].zr   = 29'(in_data.point_z) * 29'(ROWS / 2);
		nxt[0].zc   = 29'(in_data.point_z) * 29'(COLS / 2);
		nxt[0].zneg = in_data.point_z[15];
		nxt[0].zabs = in_data.point_z[15] ? 16'(-in_data.point_z) : in_data.point_z;
		nxt[0].xx   = 32'(32'(in_data.point_x) * 32'(in_data.point_x));
		nxt[0].yy   = 32'(32'(in_data.point_y) * 32'(in_data.point_y));
		nxt[0].zz   = 32'(32'(in_data.point_z) * 32'(in_data.point_z));

		for (int k = 1; k < NS; k++) begin
			nxt[k] = pipe_s[k-1];
			if (k == 1) begin
				nxt[k].fx = pipe_s[k-1].zr + pipe_s[k-1].fx;
				nxt[k].fy = pipe_s[k-1].zc + pipe_s[k-1].fy;
				nxt[k].s  = pipe_s[k-1].xx + pipe_s[k-1].yy + pipe_s[k-1].zz;
			end else if (k == 2) begin
				ra = pipe_s[k-1].fx[28] ? 29'(-pipe_s[k-1].fx) : 29'(pipe_s[k-1].fx);
				ca = pipe_s[k-1].fy[28] ? 29'(-pipe_s[k-1].fy) : 29'(pipe_s[k-1].fy);
				nxt[k].rneg = (pipe_s[k-1].fx[28] ^ pipe_s[k-1].zneg) && (ra != 29'd0);
				nxt[k].cneg = (pipe_s[k-1].fy[28] ^ pipe_s[k-1].zneg) && (ca != 29'd0);
				nxt[k].rn   = {ra, 1'b0} + 30'(pipe_s[k-1].zabs);
				nxt[k].cn   = {ca, 1'b0} + 30'(pipe_s[k-1].zabs);
				nxt[k].dd   = {pipe_s[k-1].zabs, 1'b0};
				nxt[k].rq   = '0;
				nxt[k].cq   = '0;
				nxt[k].win  = (pipe_s[k-1].s <= mxsq_q) && (pipe_s[k-1].s >= mnsq_q)
					&& (rmax_q > rmin_q);
				nxt[k].sv   = {pipe_s[k-1].s, 16'd0};
				nxt[k].sr   = '0;
			end else if (k == 27) begin
				gt = {rmax_q, 8'd0} - pipe_s[k-1].sr[23:0];
				nxt[k].gn   = {gt, 8'd0} - 32'(gt);
				nxt[k].gq   = '0;
				nxt[k].keep = pipe_s[k-1].keep
					&& !pipe_s[k-1].rovf && (!pipe_s[k-1].rneg || pipe_s[k-1].rq == 10'd0)
					&& (32'(pipe_s[k-1].rq) < 32'(ROWS))
					&& !pipe_s[k-1].covf && (!pipe_s[k-1].cneg || pipe_s[k-1].cq == 10'd0)
					&& (32'(pipe_s[k-1].cq) < 32'(COLS));
			end else if (k >= 28) begin
				if (pipe_s[k-1].gn >= (gd << (35 - k))) begin
					nxt[k].gn = pipe_s[k-1].gn - (gd << (35 - k));
					nxt[k].gq[35 - k] = 1'b1;
				end
			end

			if (k == 3) begin
				nxt[k].rovf = pipe_s[k-1].rn >= (30'(pipe_s[k-1].dd) << 10);
				nxt[k].covf = pipe_s[k-1].cn >= (30'(pipe_s[k-1].dd) << 10);
			end else if (k >= 4 && k <= 13) begin
				if (pipe_s[k-1].rn >= (30'(pipe_s[k-1].dd) << (13 - k))) begin
					nxt[k].rn = pipe_s[k-1].rn - (30'(pipe_s[k-1].dd) << (13 - k));
					nxt[k].rq[13 - k] = 1'b1;
				end
				if (pipe_s[k-1].cn >= (30'(pipe_s[k-1].dd) << (13 - k))) begin
					nxt[k].cn = pipe_s[k-1].cn - (30'(pipe_s[k-1].dd) << (13 - k));
					nxt[k].cq[13 - k] = 1'b1;
				end
			end

			if (k >= 3 && k <= 26) begin
				bitv = 48'd1 << (2 * (26 - k));
				t    = pipe_s[k-1].sr + bitv;
				if (pipe_s[k-1].sv >= t) begin
					nxt[k].sv = pipe_s[k-1].sv - t;
					nxt[k].sr = (pipe_s[k-1].sr >> 1) + bitv;
				end else begin
					nxt[k].sr = pipe_s[k-1].sr >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				pipe_s[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < NS; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ptrp_pkg::*;

	localparam int LAT = 36;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               ok;
		bit                 typed;
		bit                 hit;
		pixel_t             res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	point_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pixel_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [11:0] focal;
	logic [15:0] rmin;
	logic [15:0] rmax;
	pixel_t pixels_due[$];
	int errors = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit quiet_rx = 0;
	vec_t dir[$];

	point_to_range_pixel_projector uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint rdiv(longint num, longint den);
		longint a;
		longint q;
		a = num < 0 ? -num : num;
		q = (2 * a + den) / (2 * den);
		return num < 0 ? -q : q;
	endfunction

	function automatic longint root_of(longint v);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v)
				r = r + (64'd1 << b);
		end
		return r;
	endfunction

	function automatic bit project(input point_t p, output pixel_t px);
		longint x, y, z, f, nr, nc, d, row, col, s, mn, mx, rq, g;
		x = p.point_x;
		y = p.point_y;
		z = p.point_z;
		f = focal;
		px = '0;
		if (!p.point_valid || z == 0)
			return 0;
		nr = (ROWS / 2) * z + f * x;
		nc = (COLS / 2) * z + f * y;
		d = z;
		if (d < 0) begin
			d = -d;
			nr = -nr;
			nc = -nc;
		end
		row = rdiv(nr, d);
		col = rdiv(nc, d);
		if (row < 0 || row >= ROWS || col < 0 || col >= COLS)
			return 0;
		s = x * x + y * y + z * z;
		mn = rmin;
		mx = rmax;
		if (s > mx * mx || s < mn * mn || mx <= mn) begin
			g = 0;
		end else begin
			rq = root_of(s << 16);
			g = (255 * (mx * 256 - rq)) / ((mx - mn) * 256);
			if (g > 255)
				g = 255;
		end
		px.pixel_row = row[8:0];
		px.pixel_col = col[9:0];
		px.gray = g[7:0];
		return 1;
	endfunction

	task automatic write_reg(input logic [3:0] a, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == ADDR_FOCAL)
			focal = v[11:0];
		else if (a == ADDR_RMIN)
			rmin = v[15:0];
		else if (a == ADDR_RMAX)
			rmax = v[15:0];
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (LAT + 4)
			@(posedge clk);
	endtask

	task automatic send_point(input point_t p, input bit typed, input pixel_t want,
			input bit hit);
		pixel_t px;
		bit got;
		got = project(p, px);
		if (typed) begin
			got = hit;
			px = want;
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (got)
			pixels_due.push_back(px);
	endtask

	task automatic send_random(input int n);
		point_t p;
		int gap;
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				if (gap > 0)
					in_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
				burst = $urandom_range(1, 30);
			end
			burst--;
			p.point_valid = $urandom_range(0, 15) != 0;
			if ($urandom_range(0, 3) == 0) begin
				p.point_x = 16'($urandom);
				p.point_y = 16'($urandom);
				p.point_z = 16'($urandom);
			end else begin
				p.point_z = $urandom_range(0, 1) ? 16'($urandom_range(1, 3000))
					: 16'(-$urandom_range(1, 3000));
				p.point_x = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
				p.point_y = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
				if ($urandom_range(0, 20) == 0)
					p.point_z = 0;
			end
			send_point(p, 0, '0, 0);
		end
	endtask

	function automatic vec_t row_of(int x, int y, int z, bit ok, bit typed, bit hit,
			int r, int c, int g);
		vec_t v;
		v.x = 16'(x);
		v.y = 16'(y);
		v.z = 16'(z);
		v.ok = ok;
		v.typed = typed;
		v.hit = hit;
		v.res.pixel_row = 9'(r);
		v.res.pixel_col = 10'(c);
		v.res.gray = 8'(g);
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (quiet_rx) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				$display("%0t: unexpected item %p", $time, out_data);
				errors++;
			end else begin
				if (out_data.pixel_row !== pixels_due[0].pixel_row)
					$display("%0t: pixel_row expected %0d actual %0d", $time,
						pixels_due[0].pixel_row, out_data.pixel_row);
				if (out_data.pixel_col !== pixels_due[0].pixel_col)
					$display("%0t: pixel_col expected %0d actual %0d", $time,
						pixels_due[0].pixel_col, out_data.pixel_col);
				if (out_data.gray !== pixels_due[0].gray)
					$display("%0t: gray expected %0d actual %0d", $time,
						pixels_due[0].gray, out_data.gray);
				if (out_data !== pixels_due[0])
					errors++;
				void'(pixels_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		point_t p;
		focal = FOCAL_RST;
		rmin = RMIN_RST;
		rmax = RMAX_RST;
		dir.push_back(row_of(0, 0, 1000, 1, 1, 1, 240, 320, 127));
		dir.push_back(row_of(0, 0, 500, 1, 1, 1, 240, 320, 255));
		dir.push_back(row_of(0, 0, 1500, 1, 1, 1, 240, 320, 0));
		dir.push_back(row_of(0, 0, 400, 1, 1, 1, 240, 320, 0));
		dir.push_back(row_of(0, 0, 2000, 1, 1, 1, 240, 320, 0));
		dir.push_back(row_of(0, 0, 1000, 0, 1, 0, 0, 0, 0));
		dir.push_back(row_of(0, 0, 0, 1, 1, 0, 0, 0, 0));
		dir.push_back(row_of(0, 0, -1000, 1, 1, 1, 240, 320, 127));
		dir.push_back(row_of(32767, 0, 1000, 1, 1, 0, 0, 0, 0));
		dir.push_back(row_of(-32768, -32768, 1, 1, 1, 0, 0, 0, 0));
		dir.push_back(row_of(0, 0, 32767, 1, 1, 1, 240, 320, 0));
		dir.push_back(row_of(0, 0, -32768, 1, 1, 1, 240, 320, 0));
		dir.push_back(row_of(-32768, 32767, -32768, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(100, -100, 1000, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(-461, 0, 1000, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(460, 615, 1000, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(1, 1, 2, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(-1, -1, 2, 1, 0, 0, 0, 0, 0));
		dir.push_back(row_of(-1, 1, -2, 1, 0, 0, 0, 0, 0));
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) begin
			p.point_x = dir[i].x;
			p.point_y = dir[i].y;
			p.point_z = dir[i].z;
			p.point_valid = dir[i].ok;
			send_point(p, dir[i].typed, dir[i].res, dir[i].hit);
		end
		send_random(300);
		drain_pipe();
		write_reg(ADDR_FOCAL, 32'd1);
		write_reg(ADDR_RMIN, 32'd0);
		write_reg(ADDR_RMAX, 32'd65535);
		send_random(300);
		hold_off = 200;
		send_random(200);
		drain_pipe();
		write_reg(ADDR_FOCAL, 32'd4095);
		write_reg(ADDR_RMIN, 32'd800);
		write_reg(ADDR_RMAX, 32'd800);
		send_random(250);
		drain_pipe();
		write_reg(ADDR_FOCAL, 32'd0);
		write_reg(ADDR_RMIN, 32'd2000);
		write_reg(ADDR_RMAX, 32'd100);
		send_random(150);
		drain_pipe();
		write_reg(ADDR_FOCAL, 32'd300);
		write_reg(ADDR_RMIN, 32'd65535);
		write_reg(ADDR_RMAX, 32'd0);
		send_random(100);
		drain_pipe();
		write_reg(ADDR_FOCAL, 32'd700);
		write_reg(ADDR_RMIN, 32'd200);
		write_reg(ADDR_RMAX, 32'd3500);
		quiet_rx = 1;
		send_random(150);
		quiet_rx = 0;
		send_random(300);
		drain_pipe();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ptrp_pkg.sv
rtl/core/point_to_range_pixel_projector.sv
test/tb.sv
